@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define EBQ_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the following cycle.
`define EBQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Condition never holds.
`define EBQ_ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

`endif

@@ rtl/core/ebq_pkg.sv @@
// ----------------------------------------------------------------------------
// ebq_pkg
// Types and constants shared by the encoder and button qualifier.
// ----------------------------------------------------------------------------
package ebq_pkg;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int CFG_TIME_W = 16;
   localparam int ACCEL_W    = 7;
   localparam int STEP_W     = 8;
   localparam int PHASE_W    = 3;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 16;

   // register indexes on the csr port
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_DEBOUNCE    = 3'd0,
      CSR_LONG_PRESS  = 3'd1,
      CSR_HOLDOFF     = 3'd2,
      CSR_ACCEL_WIN   = 3'd3,
      CSR_ACCEL_STEP  = 3'd4
   } csr_index_type;

   // button phases as reported in the status word
   typedef enum logic [PHASE_W-1:0] {
      PH_UP   = 3'd0,
      PH_PDEB = 3'd1,
      PH_DOWN = 3'd2,
      PH_LONG = 3'd3,
      PH_RDEB = 3'd4
   } phase_type;

   // pending button event
   typedef enum logic [1:0] {
      EV_NONE  = 2'd0,
      EV_PRESS = 2'd1,
      EV_LONG  = 2'd2
   } event_type;

   localparam logic [CFG_TIME_W-1:0] DEBOUNCE_RST   = 16'd100;
   localparam logic [CFG_TIME_W-1:0] LONG_PRESS_RST = 16'd1000;
   localparam logic [CFG_TIME_W-1:0] HOLDOFF_RST    = 16'd100;
   localparam logic [CFG_TIME_W-1:0] ACCEL_WIN_RST  = 16'd150;
   localparam logic [ACCEL_W-1:0]    ACCEL_STEP_RST = 7'd1;

   typedef struct packed {
      logic down;
      logic ack_press;
      logic ack_long;
      logic clear_all;
   } ebq_btn_ctl_type;

   typedef struct packed {
      logic enc_edge;
      logic dir;
      logic ack_step;
      logic clear_all;
   } ebq_enc_ctl_type;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic               press_pending;
      logic               long_pending;
   } ebq_btn_status_type;

endpackage

@@ rtl/core/ebq_button.sv @@
// ----------------------------------------------------------------------------
// ebq_button
// Button debounce and long press machine, one update per accepted tick.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ebq_button import ebq_pkg::*; #(
   parameter int TIMER_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  ebq_btn_ctl_type       ctl,
   input  logic [CFG_TIME_W-1:0] debounce_ticks,
   input  logic [CFG_TIME_W-1:0] long_press_ticks,
   output ebq_btn_status_type    status
);

   localparam logic [32:0] TMAX = (33'd1 << TIMER_WIDTH) - 33'd1;

   function automatic logic [TIMER_WIDTH-1:0] load_timer(input logic [CFG_TIME_W-1:0] v);
      logic [32:0] wide;
      wide = {{(33-CFG_TIME_W){1'b0}}, v};
      if (wide > TMAX) wide = TMAX;
      return wide[TIMER_WIDTH-1:0];
   endfunction

   phase_type               phase_ff, phase_in;
   event_type               event_ff, event_in;
   logic [TIMER_WIDTH-1:0]  deb_ff, deb_in;
   logic [TIMER_WIDTH-1:0]  lp_ff, lp_in;
   logic [TIMER_WIDTH-1:0]  deb_dec, lp_dec;
   event_type               event_ack;
   logic                    long_done;
   logic                    long_raise;
   logic                    press_raise;

   always_comb begin
      // acknowledges first
      event_ack = event_ff;
      if (ctl.ack_press && event_ff == EV_PRESS) event_ack = EV_NONE;
      if (ctl.ack_long && event_ff == EV_LONG) event_ack = EV_NONE;
      if (ctl.clear_all) event_ack = EV_NONE;

      deb_dec   = (deb_ff == '0) ? '0 : deb_ff - 1'b1;
      lp_dec    = (lp_ff == '0) ? '0 : lp_ff - 1'b1;
      long_done = (lp_dec == '0);

      phase_in = phase_ff;
      event_in = event_ack;
      deb_in   = deb_dec;
      lp_in    = lp_dec;

      case (phase_ff)
         PH_UP: begin
            if (ctl.down) begin
               phase_in = PH_PDEB;
               deb_in   = load_timer(debounce_ticks);
            end
         end
         PH_PDEB: begin
            if (deb_dec == '0) begin
               if (ctl.down) begin
                  phase_in = PH_DOWN;
                  lp_in    = load_timer(long_press_ticks);
               end else begin
                  phase_in = PH_UP;
               end
            end
         end
         PH_DOWN: begin
            if (!ctl.down) begin
               phase_in = PH_RDEB;
               deb_in   = load_timer(debounce_ticks);
            end else if (long_done) begin
               phase_in = PH_LONG;
               event_in = EV_LONG;
            end
         end
         PH_LONG: begin
            if (!ctl.down) begin
               phase_in = PH_RDEB;
               deb_in   = load_timer(debounce_ticks);
            end
         end
         PH_RDEB: begin
            if (deb_dec == '0) begin
               if (!ctl.down) begin
                  if (!long_done) event_in = EV_PRESS;
                  phase_in = PH_UP;
               end else begin
                  phase_in = long_done ? PH_LONG : PH_DOWN;
               end
            end
         end
         default: begin
            phase_in = PH_UP;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_UP;
         event_ff <= EV_NONE;
         deb_ff   <= '0;
         lp_ff    <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         event_ff <= event_in;
         deb_ff   <= deb_in;
         lp_ff    <= lp_in;
      end
   end

   assign status.phase         = phase_ff;
   assign status.press_pending = (event_ff == EV_PRESS);
   assign status.long_pending  = (event_ff == EV_LONG);

   assign long_raise  = advance && event_ff != EV_LONG && event_in == EV_LONG;
   assign press_raise = advance && event_ff != EV_PRESS && event_in == EV_PRESS;

   // a long event is raised only on entry to long down
   `EBQ_ASSERT_NEXT(a_long_entry, long_raise, phase_ff == PH_LONG, "long event without long down")
   // a short press is raised only on return to up
   `EBQ_ASSERT_NEXT(a_press_entry, press_raise, phase_ff == PH_UP, "press event without up")

endmodule

@@ rtl/core/ebq_encoder.sv @@
// ----------------------------------------------------------------------------
// ebq_encoder
// Encoder edge holdoff, acceleration window and pending step register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ebq_encoder import ebq_pkg::*; #(
   parameter int TIMER_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  ebq_enc_ctl_type       ctl,
   input  logic [CFG_TIME_W-1:0] holdoff_ticks,
   input  logic [CFG_TIME_W-1:0] accel_window_ticks,
   input  logic [ACCEL_W-1:0]    accel_step,
   output logic [STEP_W-1:0]     step_value
);

   localparam logic [32:0] TMAX = (33'd1 << TIMER_WIDTH) - 33'd1;

   function automatic logic [TIMER_WIDTH-1:0] load_timer(input logic [CFG_TIME_W-1:0] v);
      logic [32:0] wide;
      wide = {{(33-CFG_TIME_W){1'b0}}, v};
      if (wide > TMAX) wide = TMAX;
      return wide[TIMER_WIDTH-1:0];
   endfunction

   logic [TIMER_WIDTH-1:0] hold_ff, hold_in;
   logic [TIMER_WIDTH-1:0] accel_ff, accel_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic [TIMER_WIDTH-1:0] hold_dec, accel_dec;
   logic [ACCEL_W-1:0]     mag;
   logic [STEP_W-1:0]      mag_ext;
   logic                   edge_take;

   always_comb begin
      hold_dec  = (hold_ff == '0) ? '0 : hold_ff - 1'b1;
      accel_dec = (accel_ff == '0) ? '0 : accel_ff - 1'b1;

      // zero magnitude acts as one
      mag = 7'd1;
      if (accel_dec != '0 && accel_step != '0) mag = accel_step;
      mag_ext = {1'b0, mag};

      step_in  = (ctl.ack_step || ctl.clear_all) ? '0 : step_ff;
      hold_in  = hold_dec;
      accel_in = accel_dec;

      edge_take = ctl.enc_edge && hold_dec == '0;
      if (edge_take) begin
         step_in  = ctl.dir ? mag_ext : (~mag_ext + 1'b1);
         accel_in = load_timer(accel_window_ticks);
         hold_in  = load_timer(holdoff_ticks);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff  <= '0;
         accel_ff <= '0;
         step_ff  <= '0;
      end else if (advance) begin
         hold_ff  <= hold_in;
         accel_ff <= accel_in;
         step_ff  <= step_in;
      end
   end

   assign step_value = step_ff;

   // an accepted edge always leaves a nonzero step
   `EBQ_ASSERT_NEXT(a_edge_step, advance && edge_take, step_ff != '0, "edge left zero step")
   // magnitude never reaches 128
   `EBQ_ASSERT_NEVER(a_step_range, step_ff == 8'h80, "step out of range")

endmodule

@@ rtl/core/encoder_button_qualifier.sv @@
// ----------------------------------------------------------------------------
// encoder_button_qualifier
// Per-tick button debounce / long press and rotary encoder step qualifier.
// ----------------------------------------------------------------------------
//
//  channel   dir  width  contents
//  req_      in   8      one millisecond tick word (levels, edge, acks, clear)
//  rsp_      out  16     qualified state after the tick
//  csr_      in   3/16   timer and acceleration settings, write only
//
//  A word accepted on req_ is held in the input register; once the result
//  slot is free the next edge runs it through the button and encoder update
//  into the state registers, which double as the result register, and
//  rsp_tvalid rises. One word per cycle is sustained while rsp_tready is
//  high; the update is a few 16-bit decrements.
//  Reset is synchronous and active high; it loads the settings defaults and
//  clears all timers, the pending step and any pending button event.
//  A stalled rsp holds the state; the input register keeps taking a word
//  while it drains, so req_tready drops only when both stages are full and
//  rsp_tready is low.
//
`include "assert_macros.svh"

module encoder_button_qualifier import ebq_pkg::*; #(
   parameter int TIMER_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [0] button_level, [1] encoder_edge, [2] direction_level, [3] ack_step,
   // [4] ack_press, [5] ack_long_press, [6] clear_all, [7] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [7:0] step_value, [8] press_pending, [9] long_press_pending,
   // [12:10] button_phase, [15:13] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,

   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // settings
   logic [CFG_TIME_W-1:0] debounce_ff;
   logic [CFG_TIME_W-1:0] long_press_ff;
   logic [CFG_TIME_W-1:0] holdoff_ff;
   logic [CFG_TIME_W-1:0] accel_win_ff;
   logic [ACCEL_W-1:0]    accel_step_ff;

   // input register and output handshake
   logic                  in_valid_ff, in_valid_in;
   logic [6:0]            in_word_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  advance;
   logic                  req_fire;
   logic                  both_full_stalled;
   logic                  both_pending;

   ebq_btn_ctl_type       btn_ctl;
   ebq_enc_ctl_type       enc_ctl;
   ebq_btn_status_type    btn_status;
   logic [STEP_W-1:0]     step_value;

   // settings writes: ignore indexes past the list
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff   <= DEBOUNCE_RST;
         long_press_ff <= LONG_PRESS_RST;
         holdoff_ff    <= HOLDOFF_RST;
         accel_win_ff  <= ACCEL_WIN_RST;
         accel_step_ff <= ACCEL_STEP_RST;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_DEBOUNCE:   debounce_ff   <= csr_wdata;
            CSR_LONG_PRESS: long_press_ff <= csr_wdata;
            CSR_HOLDOFF:    holdoff_ff    <= csr_wdata;
            CSR_ACCEL_WIN:  accel_win_ff  <= csr_wdata;
            CSR_ACCEL_STEP: accel_step_ff <= csr_wdata[ACCEL_W-1:0];
            default: ;
         endcase
      end
   end

   // advance the held word into the state when the result slot is free
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;

      rsp_valid_in = rsp_valid_ff;
      if (advance) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: hold until the next accept
   always_ff @(posedge clock) begin
      if (req_fire) in_word_ff <= req_tdata[6:0];
   end

   // split the tick word; a low button level means pressed
   assign btn_ctl.down      = !in_word_ff[0];
   assign btn_ctl.ack_press = in_word_ff[4];
   assign btn_ctl.ack_long  = in_word_ff[5];
   assign btn_ctl.clear_all = in_word_ff[6];

   assign enc_ctl.enc_edge  = in_word_ff[1];
   assign enc_ctl.dir       = in_word_ff[2];
   assign enc_ctl.ack_step  = in_word_ff[3];
   assign enc_ctl.clear_all = in_word_ff[6];

   ebq_button #(
      .TIMER_WIDTH(TIMER_WIDTH)
   ) u_button (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .ctl             (btn_ctl),
      .debounce_ticks  (debounce_ff),
      .long_press_ticks(long_press_ff),
      .status          (btn_status)
   );

   ebq_encoder #(
      .TIMER_WIDTH(TIMER_WIDTH)
   ) u_encoder (
      .clock             (clock),
      .reset             (reset),
      .advance           (advance),
      .ctl               (enc_ctl),
      .holdoff_ticks     (holdoff_ff),
      .accel_window_ticks(accel_win_ff),
      .accel_step        (accel_step_ff),
      .step_value        (step_value)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, btn_status.phase, btn_status.long_pending,
                        btn_status.press_pending, step_value};

   assign both_full_stalled = in_valid_ff && rsp_valid_ff && !rsp_tready;
   assign both_pending      = btn_status.press_pending && btn_status.long_pending;

   // every advanced word produces a result next cycle
   `EBQ_ASSERT_NEXT(a_adv_result, advance, rsp_valid_ff, "advanced word without result")
   // both stages full and stalled: no new word taken
   `EBQ_ASSERT_IMPL(a_full_stall, both_full_stalled, !req_tready, "accept while full")
   // short and long press never pending together
   `EBQ_ASSERT_NEVER(a_one_event, both_pending, "two button events pending")

endmodule
